>>> sv/min_heap_priority_queue_macros.svh
// Assertion macros shared by the priority queue RTL.
`ifndef MIN_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define MIN_HEAP_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define MHPQ_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define MHPQ_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define MHPQ_ASSERT(name, clk, rst, prop, msg)
`define MHPQ_ASSERT_NEXT(name, clk, rst, ante, cons, msg)

`endif

`endif

>>> sv/mhpq_pkg.sv
// Shared types and constants of the min-heap priority queue.
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_OUT_WIDTH = 11;

   typedef enum logic {
      MODE_PUSH = 1'b0,
      MODE_POP  = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_POP_RD,
      ST_POP_CMP,
      ST_DN_RD,
      ST_DN_CMP,
      ST_RESP
   } state_type;

   typedef struct packed {
      mode_type                       mode;
      logic signed [VALUE_WIDTH-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0]  popped_value;
      status_type                     status;
      logic [COUNT_OUT_WIDTH-1:0]     entry_count;
   } rsp_type;

endpackage

`default_nettype wire

>>> sv/mhpq_store.sv
// Heap entry memory: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_store #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

>>> sv/min_heap_priority_queue.sv
// Top level of the min-heap priority queue: control sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "min_heap_priority_queue_macros.svh"

// Binary min-heap of signed values held in a synchronous, registered-read memory.
// Request channel (req_valid, req_stall, req_data): each transfer is a push
// (mode MODE_PUSH, value) or a pop (mode MODE_POP). Response channel
// (rsp_valid, rsp_stall, rsp_data): exactly one transfer per request, in
// order, carrying popped_value, status and entry_count after the operation.
// One request is worked on at a time; req_stall is high from acceptance
// until its result has been moved into the output register.
// After acceptance, a push climbs through ST_UP_RD and ST_UP_CMP once per level
// it moves up, settling the value at the root in ST_UP_RD when it gets there; a
// pop reads the root and the last entry (ST_POP_RD, ST_POP_CMP), then sinks the
// moved entry through ST_DN_RD and ST_DN_CMP once per level (skipped when it
// empties the heap). Each level takes a memory read state and a compare/write-back
// state; the next request is taken only once the sequencer is back in ST_IDLE.
// A full push or an empty pop goes from ST_IDLE straight to ST_RESP.
// Reset empties the heap (count to zero, no memory clearing is needed since
// only entries below the count are ever used) and drops any pending result.
// A stalled response holds in the output register; the next request is still
// accepted and worked on, and its result waits until the register frees up.
module min_heap_priority_queue
   import mhpq_pkg::*;
#(
   parameter int CAPACITY   = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   input  req_type   req_data,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output rsp_type   rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = AW + 2;
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   // Sequencer state and datapath registers.
   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [AW-1:0]           pos_ff, pos_in;
   logic [DATA_WIDTH-1:0]   cur_ff, cur_in;
   logic [VALUE_WIDTH-1:0]  popped_ff, popped_in;
   status_type              status_ff, status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   // Memory port signals.
   logic [AW-1:0]           rd_addr_a;
   logic [AW-1:0]           rd_addr_b;
   logic [DATA_WIDTH-1:0]   rd_data_a;
   logic [DATA_WIDTH-1:0]   rd_data_b;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [DATA_WIDTH-1:0]   wr_data;

   logic                    req_accept;
   logic                    rsp_load;
   logic [DATA_WIDTH-1:0]   in_val;
   logic [VALUE_WIDTH-1:0]  root_val;
   logic [COUNT_OUT_WIDTH-1:0] count_out;

   // Tree navigation.
   logic [AW-1:0]           parent_idx;
   logic [IW-1:0]           left_idx;
   logic [IW-1:0]           right_idx;
   logic                    left_ok;
   logic                    right_ok;
   logic                    take_right;
   logic [DATA_WIDTH-1:0]   child_val;
   logic [AW-1:0]           child_idx;
   logic                    child_smaller;
   logic                    cur_below_parent;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = (state_ff == ST_RESP) && (!rsp_valid_ff || !rsp_stall);

   // Fit the request value to the stored width, sign-extending when wider.
   if (DATA_WIDTH <= VALUE_WIDTH) begin : g_in_narrow
      assign in_val = req_data.value[DATA_WIDTH-1:0];
   end else begin : g_in_wide
      assign in_val = {{(DATA_WIDTH - VALUE_WIDTH){req_data.value[VALUE_WIDTH-1]}},
                       req_data.value};
   end

   // Popped value leaves as the stored bits, zero-extended or truncated.
   if (DATA_WIDTH >= VALUE_WIDTH) begin : g_out_wide
      assign root_val = rd_data_a[VALUE_WIDTH-1:0];
   end else begin : g_out_narrow
      assign root_val = VALUE_WIDTH'(rd_data_a);
   end

   if (CW <= COUNT_OUT_WIDTH) begin : g_cnt_narrow
      assign count_out = COUNT_OUT_WIDTH'(count_ff);
   end else begin : g_cnt_wide
      assign count_out = count_ff[COUNT_OUT_WIDTH-1:0];
   end

   assign parent_idx = (pos_ff - AW'(1)) >> 1;
   assign left_idx   = {1'b0, pos_ff, 1'b1};
   assign right_idx  = {1'b0, pos_ff, 1'b0} + IW'(2);
   assign left_ok    = left_idx < IW'(count_ff);
   assign right_ok   = right_idx < IW'(count_ff);

   // Prefer the left child on a tie; the right one only when strictly smaller.
   assign take_right    = right_ok && ($signed(rd_data_b) < $signed(rd_data_a));
   assign child_val     = take_right ? rd_data_b : rd_data_a;
   assign child_idx     = take_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
   assign child_smaller = left_ok && ($signed(child_val) < $signed(cur_ff));

   assign cur_below_parent = $signed(cur_ff) < $signed(rd_data_a);

   mhpq_store #(
      .DEPTH (CAPACITY),
      .WIDTH (DATA_WIDTH)
   ) u_store (
      .clock     (clock),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   // Next state. Reads are issued in the *_RD states and consumed in the cycle
   // after, in the matching compare state; writes happen in compare states and
   // in ST_UP_RD at the root, and a read never meets a write to the same entry.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               priority if (req_data.mode == MODE_PUSH) begin
                  state_in = (count_ff == CAP_COUNT) ? ST_RESP : ST_UP_RD;
               end else begin
                  state_in = (count_ff == '0) ? ST_RESP : ST_POP_RD;
               end
            end
         end
         ST_UP_RD: begin
            state_in = (pos_ff == '0) ? ST_RESP : ST_UP_CMP;
         end
         ST_UP_CMP: begin
            state_in = cur_below_parent ? ST_UP_RD : ST_RESP;
         end
         ST_POP_RD: begin
            state_in = ST_POP_CMP;
         end
         ST_POP_CMP: begin
            state_in = (count_ff == CW'(1)) ? ST_RESP : ST_DN_RD;
         end
         ST_DN_RD: begin
            state_in = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            state_in = child_smaller ? ST_DN_RD : ST_RESP;
         end
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      count_in  = count_ff;
      pos_in    = pos_ff;
      cur_in    = cur_ff;
      popped_in = popped_ff;
      status_in = status_ff;
      rd_addr_a = parent_idx;
      rd_addr_b = parent_idx;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = cur_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               popped_in = '0;
               status_in = STATUS_OK;
               priority if (req_data.mode == MODE_PUSH) begin
                  if (count_ff == CAP_COUNT) begin
                     status_in = STATUS_FULL;
                  end else begin
                     // Append at the end and start the climb from there.
                     cur_in   = in_val;
                     pos_in   = count_ff[AW-1:0];
                     count_in = count_ff + CW'(1);
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end
               end
            end
         end
         ST_UP_RD: begin
            // At the root: settle the climbing value here.
            if (pos_ff == '0) begin
               wr_en = 1'b1;
            end
         end
         ST_UP_CMP: begin
            wr_en = 1'b1;
            if (cur_below_parent) begin
               // Pull the parent down into the hole and move up.
               wr_data = rd_data_a;
               pos_in  = parent_idx;
            end
         end
         ST_POP_RD: begin
            // Fetch the root and the last entry together.
            rd_addr_a = '0;
            rd_addr_b = AW'(count_ff - CW'(1));
         end
         ST_POP_CMP: begin
            popped_in = root_val;
            cur_in    = rd_data_b;
            pos_in    = '0;
            count_in  = count_ff - CW'(1);
         end
         ST_DN_RD: begin
            rd_addr_a = left_idx[AW-1:0];
            rd_addr_b = right_idx[AW-1:0];
         end
         ST_DN_CMP: begin
            wr_en = 1'b1;
            if (child_smaller) begin
               // Lift the smaller child into the hole and move down.
               wr_data = child_val;
               pos_in  = child_idx;
            end
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   // Output register: load when free or being drained, clear on transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.popped_value = popped_ff;
         rsp_data_in.status       = status_ff;
         rsp_data_in.entry_count  = count_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      cur_ff      <= cur_in;
      popped_ff   <= popped_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `MHPQ_ASSERT(a_count_bound, clock, reset, count_ff <= CAP_COUNT, "entry count above capacity")
   `MHPQ_ASSERT(a_write_in_range, clock, reset, wr_en |-> (CW'(wr_addr) < count_ff), "heap write outside live entries")
   `MHPQ_ASSERT(a_full_status, clock, reset, (rsp_load && status_ff == STATUS_FULL) |-> (count_ff == CAP_COUNT), "full status while heap not full")
   `MHPQ_ASSERT(a_empty_status, clock, reset, (rsp_load && status_ff == STATUS_EMPTY) |-> (count_ff == '0 && popped_ff == '0), "empty status with live entries or value")
   `MHPQ_ASSERT_NEXT(a_push_grows, clock, reset, req_accept && req_data.mode == MODE_PUSH && count_ff != CAP_COUNT, count_ff == $past(count_ff) + CW'(1), "accepted push did not add an entry")

endmodule

`default_nettype wire

>>> test/tb_min_heap_priority_queue.sv
// Self-checking testbench for the min-heap priority queue, checked against a shadow heap.
`timescale 1ns / 1ps

module tb_min_heap_priority_queue
   import mhpq_pkg::*;
();

   localparam int CAPACITY = 1024;
   // Leave room after the worst item for a stalled result on top.
   localparam int SETTLE_CYCLES = 40;
   localparam int DIRECTED_ROWS = 24;

   // One directed row: the request, and a hand-written result where fixed is set.
   typedef struct packed {
      mode_type                       mode;
      logic signed [VALUE_WIDTH-1:0]  value;
      logic                           fixed;
      logic signed [VALUE_WIDTH-1:0]  want_value;
      status_type                     want_status;
      logic [COUNT_OUT_WIDTH-1:0]     want_count;
   } directed_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // Shadow copy of the heap, updated at every accepted request transfer.
   logic signed [VALUE_WIDTH-1:0] shadow_heap [CAPACITY];
   int      shadow_count = 0;
   rsp_type expected_results [$];
   int      fail_count = 0;
   bit      no_idle = 1'b0;

   // Walk the heap from empty through ties and both extremes, then back to empty.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{MODE_POP,  32'sh0000_0000, 1'b1, 32'sh0000_0000, STATUS_EMPTY, 11'd0},
      '{MODE_PUSH, 32'sh7FFF_FFFF, 1'b1, 32'sh0000_0000, STATUS_OK,    11'd1},
      '{MODE_PUSH, 32'sh8000_0000, 1'b1, 32'sh0000_0000, STATUS_OK,    11'd2},
      '{MODE_PUSH, 32'sh0000_0000, 1'b0, 32'sh0000_0000, STATUS_OK,    11'd0},
      '{MODE_PUSH, -32'sd1,        1'b0, 32'sh0000_0000, STATUS_OK,    11'd0},
      '{MODE_PUSH, 32'sd1,         1'b0, 32'sh0000_0000, STATUS_OK,    11'd0},
      '{MODE_PUSH, -32'sd1,        1'b0, 32'sh0000_0000, STATUS_OK,    11'd0},
      '{MODE_PUSH, 32'sd5,         1'b0, 32'sh0000_0000, STATUS_OK,    11'd0},
      '{MODE_PUSH, 32'sd5,         1'b0, 32'sh0000_0000, STATUS_OK,    11'd0},
      '{MODE_PUSH, 32'sh5555_5555, 1'b0, 32'sh0000_0000, STATUS_OK,    11'd0},
      '{MODE_PUSH, 32'shAAAA_AAAA, 1'b0, 32'sh0000_0000, STATUS_OK,    11'd0},
      '{MODE_POP,  32'sh0000_0000, 1'b1, 32'sh8000_0000, STATUS_OK,    11'd9},
      '{MODE_POP,  32'shFFFF_FFFF, 1'b0, 32'sh0000_0000, STATUS_OK,    11'd0},
      '{MODE_POP,  32'sh0000_0000, 1'b0, 32'sh0000_0000, STATUS_OK,    11'd0},
      '{MODE_POP,  32'sh0000_0000, 1'b0, 32'sh0000_0000, STATUS_OK,    11'd0},
      '{MODE_POP,  32'sh0000_0000, 1'b0, 32'sh0000_0000, STATUS_OK,    11'd0},
      '{MODE_POP,  32'sh0000_0000, 1'b0, 32'sh0000_0000, STATUS_OK,    11'd0},
      '{MODE_POP,  32'sh0000_0000, 1'b0, 32'sh0000_0000, STATUS_OK,    11'd0},
      '{MODE_POP,  32'sh0000_0000, 1'b0, 32'sh0000_0000, STATUS_OK,    11'd0},
      '{MODE_POP,  32'sh0000_0000, 1'b0, 32'sh0000_0000, STATUS_OK,    11'd0},
      '{MODE_POP,  32'sh0000_0000, 1'b1, 32'sh7FFF_FFFF, STATUS_OK,    11'd0},
      '{MODE_POP,  32'sh0000_0000, 1'b1, 32'sh0000_0000, STATUS_EMPTY, 11'd0},
      '{MODE_PUSH, -32'sd2,        1'b0, 32'sh0000_0000, STATUS_OK,    11'd0},
      '{MODE_POP,  32'sh0000_0000, 1'b0, 32'sh0000_0000, STATUS_OK,    11'd0}
   };

   min_heap_priority_queue #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (VALUE_WIDTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one request to the shadow heap and return the result it must produce.
   // Push: append and climb while strictly below the parent. Pop: take the root,
   // move the last entry up and sink it toward the smaller child, left on a tie.
   function automatic rsp_type shadow_heap_step(req_type item);
      rsp_type                        result;
      int                             pos;
      int                             up;
      int                             best;
      int                             left;
      int                             right;
      logic signed [VALUE_WIDTH-1:0]  tmp;
      result.popped_value = '0;
      result.status       = STATUS_OK;
      if (item.mode == MODE_PUSH) begin
         if (shadow_count >= CAPACITY) begin
            result.status = STATUS_FULL;
         end else begin
            pos = shadow_count;
            shadow_heap[pos] = item.value;
            shadow_count++;
            while (pos > 0) begin
               up = (pos - 1) / 2;
               if (!(shadow_heap[pos] < shadow_heap[up])) break;
               tmp = shadow_heap[pos];
               shadow_heap[pos] = shadow_heap[up];
               shadow_heap[up] = tmp;
               pos = up;
            end
         end
      end else if (shadow_count == 0) begin
         result.status = STATUS_EMPTY;
      end else begin
         result.popped_value = shadow_heap[0];
         shadow_count--;
         shadow_heap[0] = shadow_heap[shadow_count];
         pos = 0;
         forever begin
            best  = pos;
            left  = 2 * pos + 1;
            right = 2 * pos + 2;
            if (left < shadow_count && shadow_heap[left] < shadow_heap[best]) best = left;
            if (right < shadow_count && shadow_heap[right] < shadow_heap[best]) best = right;
            if (best == pos) break;
            tmp = shadow_heap[pos];
            shadow_heap[pos] = shadow_heap[best];
            shadow_heap[best] = tmp;
            pos = best;
         end
      end
      result.entry_count = COUNT_OUT_WIDTH'(shadow_count);
      return result;
   endfunction

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int idle_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 60) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   // Mix extremes and a narrow band of small values (to force ties) into full-range noise.
   function automatic logic signed [VALUE_WIDTH-1:0] random_value();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2, 3, 4: return int'($urandom_range(0, 15)) - 8;
         default: return $urandom();
      endcase
   endfunction

   function automatic req_type random_request(int push_pct);
      req_type item;
      item.mode  = ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP;
      item.value = random_value();
      return item;
   endfunction

   // Drive one request from a falling edge, wait for its transfer and record what
   // must come back. Return at a falling edge with valid still high, so the next
   // request either follows back to back or lowers valid first.
   task automatic send_request(req_type item, bit fixed, rsp_type want);
      int      gap;
      rsp_type predicted;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = shadow_heap_step(item);
      expected_results.push_back(fixed ? want : predicted);
      @(negedge clock);
   endtask

   // Hold the request side until every outstanding result has come back.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   // Result side: stall at random, in short and long stretches.
   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         hold = idle_cycles();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   // Compare each result transfer with the oldest expectation, field by field.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual value %0d status %0d count %0d",
                     $time, rsp_data.popped_value, rsp_data.status, rsp_data.entry_count);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.popped_value !== want.popped_value) begin
               $display("%0t: popped_value mismatch: expected %0d, actual %0d",
                        $time, want.popped_value, rsp_data.popped_value);
               fail_count++;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, want.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.entry_count !== want.entry_count) begin
               $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                        $time, want.entry_count, rsp_data.entry_count);
               fail_count++;
            end
         end
      end
   end

   // Request side and end of run.
   initial begin
      req_type          item;
      rsp_type          want;
      directed_row_type row;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows: empty pop, extremes, ties, full drain back to empty.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row                = directed_rows[i];
         item.mode          = row.mode;
         item.value         = row.value;
         want.popped_value  = row.want_value;
         want.status        = row.want_status;
         want.entry_count   = row.want_count;
         send_request(item, row.fixed, want);
      end

      // Push-leaning mix: grow a shallow heap; the last stretch runs flat out.
      for (int i = 0; i < 150; i++) begin
         no_idle = ((i / 50) % 3) == 2;
         send_request(random_request(60), 1'b0, want);
      end
      no_idle = 1'b0;

      // Let everything outstanding come back before the long fill.
      hold_until_drained();

      // Fill to capacity, then push into a full heap a few times.
      while (shadow_count < CAPACITY) begin
         item.mode  = MODE_PUSH;
         item.value = random_value();
         send_request(item, 1'b0, want);
      end
      repeat (6) begin
         item.mode  = MODE_PUSH;
         item.value = random_value();
         send_request(item, 1'b0, want);
      end

      // Mix near the top of the heap, so some pushes hit the full case again.
      for (int i = 0; i < 150; i++) begin
         no_idle = ((i / 50) % 3) == 2;
         send_request(random_request(55), 1'b0, want);
      end
      no_idle = 1'b0;

      // Pop-leaning mix: shrink the deep heap with long sift-downs.
      for (int i = 0; i < 280; i++) begin
         send_request(random_request(25), 1'b0, want);
      end

      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> files.f
+incdir+sv
sv/mhpq_pkg.sv
sv/mhpq_store.sv
sv/min_heap_priority_queue.sv
test/tb_min_heap_priority_queue.sv
